@@ hw/rtl/gafs_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and codes for the grid A* first-step search core.
package gafs_pkg;

    localparam int GRID_DIM_DEF       = 64;
    localparam int OPEN_DEPTH_DEF     = 512;
    localparam int EXPANDED_DEPTH_DEF = 128;

    localparam logic [6:0] GRID_WIDTH_RST     = 7'd64;
    localparam logic [6:0] GRID_HEIGHT_RST    = 7'd64;
    localparam logic [6:0] MAX_ITERATIONS_RST = 7'd100;

    localparam logic [1:0] REG_GRID_WIDTH     = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_MAX_ITERATIONS = 2'd2;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    typedef enum logic [2:0] {
        ST_WRITE_DONE  = 3'd0,
        ST_FOUND       = 3'd1,
        ST_AT_GOAL     = 3'd2,
        ST_NO_PATH     = 3'd3,
        ST_ITER_LIMIT  = 3'd4
    } t_status;

endpackage

@@ hw/rtl/gafs_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module gafs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hw/rtl/grid_astar_first_step_core.sv @@
`timescale 1ns / 1ps
// Grid A* first-step search core: tile map, open and expanded lists, sequencer.
//
//  channel   direction  handshake         payload
//  input     in         i_valid/o_stall   i_mode, i_tile_*, i_start_*, i_goal_*
//  result    out        o_valid/i_stall   o_status, o_step_dx, o_step_dy
//  config    in         psel/penable      paddr, pwdata, prdata (pready tied high)
//
// The pace of a search is set by the single read port of the open and expanded
// list memories that every scan uses. One item is in work at a time; o_stall is
// high from acceptance until the result is placed in the output register. Reset
// is synchronous and needs no clearing pass.
module grid_astar_first_step_core
    import gafs_pkg::*;
#(
    parameter int GRID_DIM       = GRID_DIM_DEF,
    parameter int OPEN_DEPTH     = OPEN_DEPTH_DEF,
    parameter int EXPANDED_DEPTH = EXPANDED_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_mode,
    input  logic [5:0]        i_tile_x,
    input  logic [5:0]        i_tile_y,
    input  logic              i_tile_blocked,
    input  logic [5:0]        i_start_x,
    input  logic [5:0]        i_start_y,
    input  logic [5:0]        i_goal_x,
    input  logic [5:0]        i_goal_y,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_status,
    output logic signed [1:0] o_step_dx,
    output logic signed [1:0] o_step_dy,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CWG  = $clog2(GRID_DIM);
    localparam int CW   = (CWG > 6) ? CWG : 6;
    localparam int BW   = CW + 2;
    localparam int TAW  = 2 * CWG;
    localparam int PW   = $clog2(EXPANDED_DEPTH + 1);
    localparam int EAW  = $clog2(EXPANDED_DEPTH);
    localparam int OAW  = $clog2(OPEN_DEPTH);
    localparam int OCW  = $clog2(OPEN_DEPTH + 1);
    localparam int KW   = (OCW > PW) ? OCW : PW;
    localparam int SW   = ((PW > CW) ? PW : CW) + 2;
    localparam int CMPW = PW + 7;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [PW-1:0] cost;
        logic [PW-1:0] parent;
    } t_open;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [PW-1:0] parent;
    } t_done;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_CHECK  = 11'b000_0000_0010,
        S_SCAN   = 11'b000_0000_0100,
        S_SHIFT  = 11'b000_0000_1000,
        S_EXPAND = 11'b000_0001_0000,
        S_TRACE  = 11'b000_0010_0000,
        S_NBR    = 11'b000_0100_0000,
        S_TILE   = 11'b000_1000_0000,
        S_ESCAN  = 11'b001_0000_0000,
        S_OSCAN  = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [6:0]       r_cfg_w, r_cfg_h, r_cfg_mi;
    logic [CW-1:0]    r_sx, n_sx, r_sy, n_sy, r_gx, n_gx, r_gy, n_gy;
    logic [OCW-1:0]   r_ocnt, n_ocnt;
    logic [PW-1:0]    r_ecnt, n_ecnt, r_iter, n_iter;
    logic [KW-1:0]    r_k, n_k, r_pidx, n_pidx, r_best, n_best;
    logic             r_pend, n_pend;
    logic [SW-1:0]    r_bscore, n_bscore;
    t_open            r_cur, n_cur;
    logic [1:0]       r_dir, n_dir;
    logic [CW-1:0]    r_nx, n_nx, r_ny, n_ny;
    t_status          r_res_status, n_res_status;
    logic signed [1:0] r_res_dx, n_res_dx, r_res_dy, n_res_dy;
    logic             r_ovalid;
    t_status          r_ostatus;
    logic signed [1:0] r_odx, r_ody;

    logic             in_acc, cfg_wr, out_load, go_next;
    logic [BW-1:0]    w_lim, h_lim, nb_x, nb_y, tx_ext, ty_ext;
    logic             nb_ok;
    logic [CW-1:0]    ad_x, ad_y, step_x, step_y;
    logic [SW-1:0]    score;
    logic [PW-1:0]    ncost;
    logic [KW-1:0]    pidx_m1;

    logic             tm_we, tm_rdata;
    logic [TAW-1:0]   tm_waddr, tm_raddr;
    logic             op_we;
    logic [OAW-1:0]   op_waddr, op_raddr;
    t_open            op_wdata, op_rdata;
    logic             ex_we;
    logic [EAW-1:0]   ex_waddr, ex_raddr;
    t_done            ex_wdata, ex_rdata;

    gafs_ram #(.WIDTH(1), .DEPTH(1 << TAW)) u_tile_ram (
        .i_clk(i_clk), .i_we(tm_we), .i_waddr(tm_waddr), .i_wdata(i_tile_blocked),
        .i_raddr(tm_raddr), .o_rdata(tm_rdata)
    );

    gafs_ram #(.WIDTH($bits(t_open)), .DEPTH(OPEN_DEPTH)) u_open_ram (
        .i_clk(i_clk), .i_we(op_we), .i_waddr(op_waddr), .i_wdata(op_wdata),
        .i_raddr(op_raddr), .o_rdata(op_rdata)
    );

    gafs_ram #(.WIDTH($bits(t_done)), .DEPTH(EXPANDED_DEPTH)) u_done_ram (
        .i_clk(i_clk), .i_we(ex_we), .i_waddr(ex_waddr), .i_wdata(ex_wdata),
        .i_raddr(ex_raddr), .o_rdata(ex_rdata)
    );

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        case (paddr[3:2])
            REG_GRID_WIDTH:     prdata = {25'd0, r_cfg_w};
            REG_GRID_HEIGHT:    prdata = {25'd0, r_cfg_h};
            REG_MAX_ITERATIONS: prdata = {25'd0, r_cfg_mi};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= GRID_WIDTH_RST;
            r_cfg_h  <= GRID_HEIGHT_RST;
            r_cfg_mi <= MAX_ITERATIONS_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_GRID_WIDTH:     r_cfg_w  <= pwdata[6:0];
                REG_GRID_HEIGHT:    r_cfg_h  <= pwdata[6:0];
                REG_MAX_ITERATIONS: r_cfg_mi <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    assign w_lim = (BW'(r_cfg_w) < BW'(GRID_DIM)) ? BW'(r_cfg_w) : BW'(GRID_DIM);
    assign h_lim = (BW'(r_cfg_h) < BW'(GRID_DIM)) ? BW'(r_cfg_h) : BW'(GRID_DIM);

    always_comb begin
        nb_ok = 1'b1;
        nb_x  = BW'(r_cur.x);
        nb_y  = BW'(r_cur.y);
        case (r_dir)
            DIR_UP: begin
                if (r_cur.y == '0) begin
                    nb_ok = 1'b0;
                end else begin
                    nb_y = BW'(r_cur.y) - BW'(1);
                end
            end
            DIR_RIGHT: nb_x = BW'(r_cur.x) + BW'(1);
            DIR_DOWN:  nb_y = BW'(r_cur.y) + BW'(1);
            DIR_LEFT: begin
                if (r_cur.x == '0) begin
                    nb_ok = 1'b0;
                end else begin
                    nb_x = BW'(r_cur.x) - BW'(1);
                end
            end
            default: nb_ok = 1'b0;
        endcase
        if (nb_x >= w_lim || nb_y >= h_lim) begin
            nb_ok = 1'b0;
        end
    end

    assign tx_ext   = BW'(i_tile_x);
    assign ty_ext   = BW'(i_tile_y);
    assign tm_we    = in_acc && !i_mode && tx_ext < BW'(GRID_DIM) && ty_ext < BW'(GRID_DIM);
    assign tm_waddr = {ty_ext[CWG-1:0], tx_ext[CWG-1:0]};
    assign tm_raddr = {nb_y[CWG-1:0], nb_x[CWG-1:0]};

    assign ad_x    = (op_rdata.x > r_gx) ? op_rdata.x - r_gx : r_gx - op_rdata.x;
    assign ad_y    = (op_rdata.y > r_gy) ? op_rdata.y - r_gy : r_gy - op_rdata.y;
    assign score   = SW'(op_rdata.cost) + SW'(ad_x) + SW'(ad_y);
    assign ncost   = r_cur.cost + PW'(1);
    assign pidx_m1 = r_pidx - KW'(1);
    assign step_x  = r_cur.x - r_sx;
    assign step_y  = r_cur.y - r_sy;

    always_comb begin
        n_state      = r_state;
        n_sx         = r_sx;
        n_sy         = r_sy;
        n_gx         = r_gx;
        n_gy         = r_gy;
        n_ocnt       = r_ocnt;
        n_ecnt       = r_ecnt;
        n_iter       = r_iter;
        n_k          = r_k;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_best       = r_best;
        n_bscore     = r_bscore;
        n_cur        = r_cur;
        n_dir        = r_dir;
        n_nx         = r_nx;
        n_ny         = r_ny;
        n_res_status = r_res_status;
        n_res_dx     = r_res_dx;
        n_res_dy     = r_res_dy;
        go_next      = 1'b0;
        out_load     = 1'b0;
        op_we        = 1'b0;
        op_waddr     = r_ocnt[OAW-1:0];
        op_wdata     = r_cur;
        op_raddr     = r_k[OAW-1:0];
        ex_we        = 1'b0;
        ex_waddr     = r_ecnt[EAW-1:0];
        ex_wdata.x      = r_cur.x;
        ex_wdata.y      = r_cur.y;
        ex_wdata.parent = r_cur.parent;
        ex_raddr     = r_k[EAW-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_dx = '0;
                    n_res_dy = '0;
                    if (!i_mode) begin
                        n_res_status = ST_WRITE_DONE;
                        n_state      = S_DONE;
                    end else begin
                        n_sx   = CW'(i_start_x);
                        n_sy   = CW'(i_start_y);
                        n_gx   = CW'(i_goal_x);
                        n_gy   = CW'(i_goal_y);
                        n_ocnt = '0;
                        n_ecnt = '0;
                        n_iter = '0;
                        if (i_start_x == i_goal_x && i_start_y == i_goal_y) begin
                            n_res_status = ST_AT_GOAL;
                            n_state      = S_DONE;
                        end else begin
                            op_we           = 1'b1;
                            op_waddr        = '0;
                            op_wdata.x      = CW'(i_start_x);
                            op_wdata.y      = CW'(i_start_y);
                            op_wdata.cost   = '0;
                            op_wdata.parent = '0;
                            n_ocnt          = OCW'(1);
                            n_state         = S_CHECK;
                        end
                    end
                end
            end
            S_CHECK: begin
                if (r_ocnt == '0) begin
                    n_res_status = ST_NO_PATH;
                    n_state      = S_DONE;
                end else if (CMPW'(r_cfg_mi) < CMPW'(r_iter)
                             || r_ecnt >= PW'(EXPANDED_DEPTH)) begin
                    n_res_status = ST_ITER_LIMIT;
                    n_state      = S_DONE;
                end else begin
                    n_k     = '0;
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_pend = 1'b0;
                if (r_k < KW'(r_ocnt)) begin
                    n_k    = r_k + KW'(1);
                    n_pend = 1'b1;
                    n_pidx = r_k;
                end
                if (r_pend && (r_pidx == '0 || score < r_bscore)) begin
                    n_best   = r_pidx;
                    n_bscore = score;
                    n_cur    = op_rdata;
                end
                if (!r_pend && r_k >= KW'(r_ocnt)) begin
                    n_k     = r_best + KW'(1);
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_pend = 1'b0;
                if (r_k < KW'(r_ocnt)) begin
                    n_k    = r_k + KW'(1);
                    n_pend = 1'b1;
                    n_pidx = r_k;
                end
                if (r_pend) begin
                    op_we    = 1'b1;
                    op_waddr = pidx_m1[OAW-1:0];
                    op_wdata = op_rdata;
                end
                if (!r_pend && r_k >= KW'(r_ocnt)) begin
                    n_ocnt  = r_ocnt - OCW'(1);
                    n_state = S_EXPAND;
                end
            end
            S_EXPAND: begin
                ex_we  = 1'b1;
                n_ecnt = r_ecnt + PW'(1);
                n_pend = 1'b0;
                if (r_cur.x == r_gx && r_cur.y == r_gy) begin
                    n_state = S_TRACE;
                end else begin
                    n_dir   = DIR_UP;
                    n_state = S_NBR;
                end
            end
            S_TRACE: begin
                ex_raddr = r_cur.parent[EAW-1:0];
                if (r_pend) begin
                    n_cur.x      = ex_rdata.x;
                    n_cur.y      = ex_rdata.y;
                    n_cur.parent = ex_rdata.parent;
                    n_pend       = 1'b0;
                end else if (r_cur.parent == '0) begin
                    n_res_status = ST_FOUND;
                    n_res_dx     = step_x[1:0];
                    n_res_dy     = step_y[1:0];
                    n_state      = S_DONE;
                end else begin
                    n_pend = 1'b1;
                end
            end
            S_NBR: begin
                if (!nb_ok) begin
                    go_next = 1'b1;
                end else begin
                    n_nx    = nb_x[CW-1:0];
                    n_ny    = nb_y[CW-1:0];
                    n_state = S_TILE;
                end
            end
            S_TILE: begin
                if (tm_rdata) begin
                    go_next = 1'b1;
                end else begin
                    n_k     = '0;
                    n_pend  = 1'b0;
                    n_state = S_ESCAN;
                end
            end
            S_ESCAN: begin
                n_pend = 1'b0;
                if (r_k < KW'(r_ecnt)) begin
                    n_k    = r_k + KW'(1);
                    n_pend = 1'b1;
                    n_pidx = r_k;
                end
                if (r_pend && ex_rdata.x == r_nx && ex_rdata.y == r_ny) begin
                    go_next = 1'b1;
                end
                if (!r_pend && r_k >= KW'(r_ecnt)) begin
                    n_k     = '0;
                    n_state = S_OSCAN;
                end
            end
            S_OSCAN: begin
                n_pend = 1'b0;
                if (r_k < KW'(r_ocnt)) begin
                    n_k    = r_k + KW'(1);
                    n_pend = 1'b1;
                    n_pidx = r_k;
                end
                if (r_pend && op_rdata.x == r_nx && op_rdata.y == r_ny) begin
                    if (ncost < op_rdata.cost) begin
                        op_we           = 1'b1;
                        op_waddr        = r_pidx[OAW-1:0];
                        op_wdata.x      = r_nx;
                        op_wdata.y      = r_ny;
                        op_wdata.cost   = ncost;
                        op_wdata.parent = r_iter;
                    end
                    go_next = 1'b1;
                end
                if (!r_pend && r_k >= KW'(r_ocnt)) begin
                    if (r_ocnt < OCW'(OPEN_DEPTH)) begin
                        op_we           = 1'b1;
                        op_wdata.x      = r_nx;
                        op_wdata.y      = r_ny;
                        op_wdata.cost   = ncost;
                        op_wdata.parent = r_iter;
                        n_ocnt          = r_ocnt + OCW'(1);
                    end
                    go_next = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (go_next) begin
            n_pend = 1'b0;
            if (r_dir == DIR_LEFT) begin
                n_iter  = r_iter + PW'(1);
                n_state = S_CHECK;
            end else begin
                n_dir   = r_dir + 2'd1;
                n_state = S_NBR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ocnt   <= '0;
            r_ecnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ocnt  <= n_ocnt;
            r_ecnt  <= n_ecnt;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx         <= n_sx;
        r_sy         <= n_sy;
        r_gx         <= n_gx;
        r_gy         <= n_gy;
        r_iter       <= n_iter;
        r_k          <= n_k;
        r_pend       <= n_pend;
        r_pidx       <= n_pidx;
        r_best       <= n_best;
        r_bscore     <= n_bscore;
        r_cur        <= n_cur;
        r_dir        <= n_dir;
        r_nx         <= n_nx;
        r_ny         <= n_ny;
        r_res_status <= n_res_status;
        r_res_dx     <= n_res_dx;
        r_res_dy     <= n_res_dy;
        if (out_load) begin
            r_ostatus <= r_res_status;
            r_odx     <= r_res_dx;
            r_ody     <= r_res_dy;
        end
    end

    assign o_valid   = r_ovalid;
    assign o_status  = r_ostatus;
    assign o_step_dx = r_odx;
    assign o_step_dy = r_ody;

endmodule

@@ hw/rtl/gafs_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for the grid A* first-step search core, with its bind.
module gafs_chk
    import gafs_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [2:0]        o_status,
    input logic signed [1:0] o_step_dx,
    input logic signed [1:0] o_step_dy
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
            && $stable(o_step_dx) && $stable(o_step_dy))
        else $error("result changed while stalled");

    a_zero_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_FOUND |-> o_step_dx == 2'sd0 && o_step_dy == 2'sd0)
        else $error("step reported without a path");

    a_unit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FOUND |-> (o_step_dx != 2'sd0) != (o_step_dy != 2'sd0))
        else $error("found step is not a unit step");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted transaction without going busy");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("not idle after reset");

endmodule

bind grid_astar_first_step_core gafs_chk u_gafs_chk (.*);
